// File: sv/rfe_pkg.sv
package rfe_pkg;

    // Operation codes carried on the func field
    typedef enum logic [2:0] {
        FN_LOAD_COEF = 3'd0,
        FN_LOAD_MOD  = 3'd1,
        FN_WRITE_CNT = 3'd2,
        FN_TEST      = 3'd3,
        FN_FIRE      = 3'd4,
        FN_APPLY     = 3'd5,
        FN_READ_CNT  = 3'd6
    } func_t;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_INFEASIBLE = 2'd1;
    localparam logic [1:0] STATUS_RANGE      = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SPECIES_IN_USE   = 2'd0;
    localparam logic [1:0] CFG_REACTIONS_IN_USE = 2'd1;
    localparam logic [1:0] CFG_CHECK_MODE       = 2'd2;

    localparam int CFG_DATA_W = 7;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_APPLY,
        S_FINISH
    } state_t;

    // Kind of result word to build
    typedef enum logic [2:0] {
        RES_OK,
        RES_RANGE,
        RES_FAIL,
        RES_FIRED,
        RES_READ
    } res_t;

    // Controller to datapath commands
    typedef struct packed {
        logic  latch;       // capture the incoming word
        logic  wr_coef;     // write coefficient table
        logic  wr_mod;      // write modifier table
        logic  wr_cnt;      // write species count
        logic  rd_cnt;      // read species count for a read op
        logic  pass_start;  // start a walk over the species rows
        logic  pass_apply;  // walk updates counts (else checks them)
        logic  out_load;    // load the output register
        res_t  res;         // what the output register gets
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        func_t func;
        logic  s_ok;
        logic  r_ok;
        logic  pass_busy;
        logic  check_fail;
    } stat_t;

endpackage

// File: sv/rfe_ctrl.sv
module rfe_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  rfe_pkg::stat_t stat,
    output rfe_pkg::cmd_t  cmd
);

    rfe_pkg::state_t state_reg;
    rfe_pkg::state_t state_next;
    rfe_pkg::res_t   res_reg;
    rfe_pkg::res_t   res_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    // State, pending result code and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfe_pkg::S_IDLE;
            res_reg       <= rfe_pkg::RES_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == rfe_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.res        = res_reg;

        case (state_reg)
            rfe_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = rfe_pkg::S_DECODE;
                end
            end

            rfe_pkg::S_DECODE:
            begin
                state_next = rfe_pkg::S_FINISH;
                res_next   = rfe_pkg::RES_OK;
                case (stat.func)
                    rfe_pkg::FN_LOAD_COEF:
                    begin
                        if (stat.s_ok && stat.r_ok)
                            cmd.wr_coef = 1'b1;
                        else
                            res_next = rfe_pkg::RES_RANGE;
                    end
                    rfe_pkg::FN_LOAD_MOD:
                    begin
                        if (stat.s_ok && stat.r_ok)
                            cmd.wr_mod = 1'b1;
                        else
                            res_next = rfe_pkg::RES_RANGE;
                    end
                    rfe_pkg::FN_WRITE_CNT:
                    begin
                        if (stat.s_ok)
                            cmd.wr_cnt = 1'b1;
                        else
                            res_next = rfe_pkg::RES_RANGE;
                    end
                    rfe_pkg::FN_READ_CNT:
                    begin
                        if (stat.s_ok)
                        begin
                            cmd.rd_cnt = 1'b1;
                            res_next   = rfe_pkg::RES_READ;
                        end
                        else
                        begin
                            res_next = rfe_pkg::RES_RANGE;
                        end
                    end
                    rfe_pkg::FN_TEST,
                    rfe_pkg::FN_FIRE:
                    begin
                        if (stat.r_ok)
                        begin
                            cmd.pass_start = 1'b1;
                            state_next     = rfe_pkg::S_CHECK;
                        end
                        else
                        begin
                            res_next = rfe_pkg::RES_RANGE;
                        end
                    end
                    rfe_pkg::FN_APPLY:
                    begin
                        if (stat.r_ok)
                        begin
                            cmd.pass_start = 1'b1;
                            cmd.pass_apply = 1'b1;
                            state_next     = rfe_pkg::S_APPLY;
                        end
                        else
                        begin
                            res_next = rfe_pkg::RES_RANGE;
                        end
                    end
                    default:
                    begin
                        res_next = rfe_pkg::RES_OK;
                    end
                endcase
            end

            // Wait for the check walk to drain
            rfe_pkg::S_CHECK:
            begin
                if (!stat.pass_busy)
                begin
                    if (stat.check_fail)
                    begin
                        res_next   = rfe_pkg::RES_FAIL;
                        state_next = rfe_pkg::S_FINISH;
                    end
                    else if (stat.func == rfe_pkg::FN_FIRE)
                    begin
                        cmd.pass_start = 1'b1;
                        cmd.pass_apply = 1'b1;
                        state_next     = rfe_pkg::S_APPLY;
                    end
                    else
                    begin
                        res_next   = rfe_pkg::RES_FIRED;
                        state_next = rfe_pkg::S_FINISH;
                    end
                end
            end

            // Wait for the update walk to drain
            rfe_pkg::S_APPLY:
            begin
                if (!stat.pass_busy)
                begin
                    res_next   = rfe_pkg::RES_FIRED;
                    state_next = rfe_pkg::S_FINISH;
                end
            end

            // Hand the result to the output register once it is free
            rfe_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rfe_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rfe_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/rfe_dpath.sv
module rfe_dpath
#(
    parameter int MAX_SPECIES   = 32,
    parameter int MAX_REACTIONS = 64,
    parameter int COUNT_WIDTH   = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [rfe_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [2:0]                        func,
    input  logic [4:0]                        species_index,
    input  logic [5:0]                        reaction_index,
    input  logic signed [7:0]                 coefficient,
    input  logic [3:0]                        modifier_count,
    input  logic [31:0]                       count_value,
    output logic                              fired,
    output logic [31:0]                       count_out,
    output logic [1:0]                        status,
    input  rfe_pkg::cmd_t                     cmd,
    output rfe_pkg::stat_t                    stat
);

    localparam int TDEPTH = MAX_SPECIES * MAX_REACTIONS;
    localparam int TA_W   = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int SIDX_W = (MAX_SPECIES > 1) ? $clog2(MAX_SPECIES) : 1;
    localparam int ROW_W  = $clog2(MAX_SPECIES + 1);
    localparam int CX     = COUNT_WIDTH + 1;

    // Configuration registers
    logic [5:0] species_in_use_reg;
    logic [6:0] reactions_in_use_reg;
    logic       check_mode_reg;

    // Latched input word
    rfe_pkg::func_t           func_reg;
    logic [4:0]               s_reg;
    logic [5:0]               r_reg;
    logic signed [7:0]        coef_reg;
    logic [3:0]               mod_reg;
    logic [COUNT_WIDTH-1:0]   val_reg;
    logic                     s_ok_reg;
    logic                     r_ok_reg;

    // Memories
    logic signed [7:0]        coef_mem [TDEPTH];
    logic [3:0]               mod_mem  [TDEPTH];
    logic [COUNT_WIDTH-1:0]   cnt_mem  [MAX_SPECIES];
    logic [MAX_SPECIES-1:0]   cnt_valid_reg;
    logic signed [7:0]        coef_rd_reg;
    logic [3:0]               mod_rd_reg;
    logic [COUNT_WIDTH-1:0]   cnt_rd_reg;
    logic                     cval_rd_reg;

    // Row walker
    logic                     run_reg;
    logic                     apply_reg;
    logic                     fail_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [TA_W-1:0]          taddr_reg;
    logic                     p1_valid_reg;
    logic [SIDX_W-1:0]        p1_row_reg;

    // Output register
    logic                     fired_reg;
    logic [31:0]              cout_reg;
    logic [1:0]               status_reg;

    logic [ROW_W-1:0]         rows_n;
    logic                     issue;
    logic [31:0]              s_ext;
    logic [31:0]              taddr_w_full;
    logic [TA_W-1:0]          taddr_w;
    logic [SIDX_W-1:0]        s_addr;
    logic [SIDX_W-1:0]        cnt_raddr;
    logic                     cnt_re;
    logic                     cnt_we;
    logic [SIDX_W-1:0]        cnt_waddr;
    logic [COUNT_WIDTH-1:0]   cnt_wdata;
    logic [COUNT_WIDTH-1:0]   cnt_eff;
    logic [7:0]               need;
    logic [7:0]               gain;
    logic [CX-1:0]            cnt_x;
    logic [CX-1:0]            sum_x;
    logic                     row_fail;
    logic [COUNT_WIDTH-1:0]   cnt_new;
    logic [63:0]              val_ext;
    logic [63:0]              cnt_ext;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            species_in_use_reg   <= 6'd32;
            reactions_in_use_reg <= 7'd64;
            check_mode_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rfe_pkg::CFG_SPECIES_IN_USE:   species_in_use_reg   <= cfg_data[5:0];
                rfe_pkg::CFG_REACTIONS_IN_USE: reactions_in_use_reg <= cfg_data[6:0];
                rfe_pkg::CFG_CHECK_MODE:       check_mode_reg       <= cfg_data[0];
                default:                       check_mode_reg       <= check_mode_reg;
            endcase
        end
    end

    // Rows in use, saturated at the table height
    always_comb
    begin
        if (32'(species_in_use_reg) > MAX_SPECIES)
            rows_n = ROW_W'(MAX_SPECIES);
        else
            rows_n = ROW_W'(species_in_use_reg);
    end

    // Capture the input word and its range checks
    assign val_ext = 64'(count_value);

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg <= rfe_pkg::func_t'(func);
            s_reg    <= species_index;
            r_reg    <= reaction_index;
            coef_reg <= coefficient;
            mod_reg  <= modifier_count;
            val_reg  <= val_ext[COUNT_WIDTH-1:0];
            s_ok_reg <= (32'(species_index) < 32'(rows_n));
            r_ok_reg <= (7'(reaction_index) < reactions_in_use_reg)
                        && (32'(reaction_index) < MAX_REACTIONS);
        end
    end

    // Addresses for single-entry operations
    assign s_ext        = 32'(s_reg);
    assign taddr_w_full = s_ext * 32'(MAX_REACTIONS) + 32'(r_reg);
    assign taddr_w      = taddr_w_full[TA_W-1:0];
    assign s_addr       = s_ext[SIDX_W-1:0];

    // Row walker: one row read per cycle, evaluated the cycle after
    assign issue = run_reg && (row_reg < rows_n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            apply_reg    <= 1'b0;
            fail_reg     <= 1'b0;
            row_reg      <= '0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= issue;
            if (cmd.pass_start)
            begin
                run_reg   <= 1'b1;
                apply_reg <= cmd.pass_apply;
                fail_reg  <= 1'b0;
                row_reg   <= '0;
            end
            else
            begin
                if (issue)
                    row_reg <= row_reg + ROW_W'(1);
                else if (run_reg)
                    run_reg <= 1'b0;
                if (p1_valid_reg && !apply_reg && row_fail)
                    fail_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pass_start)
            taddr_reg <= TA_W'(r_reg);
        else if (issue)
            taddr_reg <= taddr_reg + TA_W'(MAX_REACTIONS);
        if (issue)
            p1_row_reg <= row_reg[SIDX_W-1:0];
    end

    // Coefficient and modifier tables
    always_ff @(posedge clk)
    begin
        if (cmd.wr_coef)
            coef_mem[taddr_w] <= coef_reg;
        if (cmd.wr_mod)
            mod_mem[taddr_w] <= mod_reg;
        if (issue)
        begin
            coef_rd_reg <= coef_mem[taddr_reg];
            mod_rd_reg  <= mod_mem[taddr_reg];
        end
    end

    // Species counts, never-written rows read as zero
    assign cnt_re    = issue || cmd.rd_cnt;
    assign cnt_raddr = issue ? row_reg[SIDX_W-1:0] : s_addr;
    assign cnt_we    = cmd.wr_cnt || (p1_valid_reg && apply_reg);
    assign cnt_waddr = cmd.wr_cnt ? s_addr : p1_row_reg;
    assign cnt_wdata = cmd.wr_cnt ? val_reg : cnt_new;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cnt_re)
            cnt_rd_reg <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= '0;
            cval_rd_reg   <= 1'b0;
        end
        else
        begin
            if (cnt_we)
                cnt_valid_reg[cnt_waddr] <= 1'b1;
            if (cnt_re)
                cval_rd_reg <= cnt_valid_reg[cnt_raddr];
        end
    end

    assign cnt_eff = cval_rd_reg ? cnt_rd_reg : '0;

    // Per-row check and saturating update
    always_comb
    begin
        need  = coef_rd_reg[7] ? (~coef_rd_reg + 8'd1) : 8'd0;
        gain  = coef_rd_reg[7] ? 8'd0 : coef_rd_reg;
        cnt_x = {1'b0, cnt_eff};

        if (check_mode_reg)
            row_fail = (cnt_x < CX'(need)) || (cnt_x < CX'(mod_rd_reg));
        else
            row_fail = cnt_x < (CX'(need) + CX'(mod_rd_reg));

        sum_x = cnt_x + CX'(gain);
        if (coef_rd_reg[7])
            cnt_new = (cnt_x >= CX'(need)) ? (cnt_eff - COUNT_WIDTH'(need)) : '0;
        else if (sum_x[COUNT_WIDTH])
            cnt_new = '1;
        else
            cnt_new = sum_x[COUNT_WIDTH-1:0];
    end

    // Output register
    assign cnt_ext = 64'(cnt_eff);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            fired_reg  <= 1'b0;
            cout_reg   <= '0;
            status_reg <= rfe_pkg::STATUS_OK;
            case (cmd.res)
                rfe_pkg::RES_RANGE: status_reg <= rfe_pkg::STATUS_RANGE;
                rfe_pkg::RES_FAIL:  status_reg <= rfe_pkg::STATUS_INFEASIBLE;
                rfe_pkg::RES_FIRED: fired_reg  <= 1'b1;
                rfe_pkg::RES_READ:  cout_reg   <= cnt_ext[31:0];
                default:            status_reg <= rfe_pkg::STATUS_OK;
            endcase
        end
    end

    assign fired     = fired_reg;
    assign count_out = cout_reg;
    assign status    = status_reg;

    // Status to the controller
    assign stat.func       = func_reg;
    assign stat.s_ok       = s_ok_reg;
    assign stat.r_ok       = r_ok_reg;
    assign stat.pass_busy  = run_reg || p1_valid_reg;
    assign stat.check_fail = fail_reg;

endmodule

// File: sv/reaction_fire_engine.sv
// Reaction update unit for stochastic simulation. One input word carries one operation
// (load coefficient, load modifier, write count, test, fire, unconditional apply,
// read count) and returns exactly one result word. Loads, count writes, reads and
// unused codes are finished at decode. A test and an unconditional apply each make
// one walk over the species rows in use; a fire makes one walk to check and, when
// the test passes, a second walk to update. The walks are made by the row walker,
// which reads one row of the coefficient, modifier and count memories per cycle
// through their single read ports. One word is in progress at a time; a new word is
// taken as soon as the previous one has moved to the output register. Species counts
// reset to zero through per-row valid bits, so no clearing pass follows reset. Table
// entries read before they are written return arbitrary values. Configuration may be
// written only while no word is in progress.
module reaction_fire_engine
#(
    parameter int MAX_SPECIES   = 32,
    parameter int MAX_REACTIONS = 64,
    parameter int COUNT_WIDTH   = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [rfe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     func,
    input  logic [4:0]                     species_index,
    input  logic [5:0]                     reaction_index,
    input  logic signed [7:0]              coefficient,
    input  logic [3:0]                     modifier_count,
    input  logic [31:0]                    count_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           fired,
    output logic [31:0]                    count_out,
    output logic [1:0]                     status
);

    rfe_pkg::cmd_t  cmd;
    rfe_pkg::stat_t stat;

    // Sequencer
    rfe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Tables, counts and row walker
    rfe_dpath
    #(
        .MAX_SPECIES   (MAX_SPECIES),
        .MAX_REACTIONS (MAX_REACTIONS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    )
    u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (func),
        .species_index  (species_index),
        .reaction_index (reaction_index),
        .coefficient    (coefficient),
        .modifier_count (modifier_count),
        .count_value    (count_value),
        .fired          (fired),
        .count_out      (count_out),
        .status         (status),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule
